// ----- rtl/core/gsm_a5_pkg.sv -----
// Shared types and constants for the GSM A5/1 and A5/2 keystream generator.
// No dependencies; imported by the interface, the LFSR core and the top level.

package gsm_a5_pkg;

    localparam int KEY_BITS   = 64;
    localparam int FRAME_BITS = 22;
    localparam int LOAD_BITS  = KEY_BITS + FRAME_BITS;
    localparam int STEP_W     = 7;
    localparam int WORD_W     = 16;
    localparam int ADDR_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [STEP_W-1:0] LOAD_LAST     = STEP_W'(LOAD_BITS - 1);
    localparam logic [STEP_W-1:0] WARM_LAST_A51 = STEP_W'(100 - 1);
    localparam logic [STEP_W-1:0] WARM_LAST_A52 = STEP_W'(99 - 1);

    localparam logic [18:0] TAPS_ONE   = 19'h72000;
    localparam logic [21:0] TAPS_TWO   = 22'h300000;
    localparam logic [22:0] TAPS_THREE = 23'h700080;
    localparam logic [16:0] TAPS_FOUR  = 17'h10800;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM_SELECT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DESTINATION_BASE = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FIX,
        ST_WARM,
        ST_RUN
    } seq_state_t;

    typedef struct packed {
        logic [10:0] frame_t1;
        logic [4:0]  frame_t2;
        logic [5:0]  frame_t3;
    } frame_req_t;

    typedef struct packed {
        logic              burst_index;
        logic [ADDR_W-1:0] word_address;
        logic [WORD_W-1:0] keystream_word;
        logic [WORD_W-1:0] valid_bits;
        logic              last_word;
    } ks_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
    } cfg_req_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic force_clk;
        logic a52;
        logic load_en;
        logic load_bit;
        logic set_fixed;
    } lfsr_ctrl_t;

endpackage

// ----- rtl/core/gsm_a5_stream_if.sv -----
// Valid/ready channel carrying one request of a chosen payload type.
// Depends on gsm_a5_pkg for the default payload type.

interface gsm_a5_stream_if
    import gsm_a5_pkg::*;
#(
    parameter type payload_t = frame_req_t
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/gsm_a51_a52_keystream_generator.sv -----
// Top level: configuration registers, run sequencer and keystream word packer.
// Depends on gsm_a5_pkg, gsm_a5_stream_if and gsm_a5_lfsr_core.
// Sequence: the key and frame bits are loaded, A5/2 then sets its fixed bits, and the
// warm-up steps run before keystream words are packed in the output phase.
// Throughput: one LFSR step per cycle, except in the fixed-bit phase and while a word
// waits to be taken; a new request is accepted only once the run has ended.
// Reset clears the sequencer, LFSRs and configuration; ready rises once the run ends.

module gsm_a51_a52_keystream_generator
    import gsm_a5_pkg::*;
#(
    parameter int NORMAL_BURST_BITS = 114,
    parameter int EDGE_BURST_BITS   = 348,
    parameter int BURST_STRIDE      = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    gsm_a5_stream_if.sink   frame,
    gsm_a5_stream_if.source keystream,
    gsm_a5_stream_if.sink   cfg
);

    localparam int MAX_BITS = (NORMAL_BURST_BITS > EDGE_BURST_BITS) ?
                              NORMAL_BURST_BITS : EDGE_BURST_BITS;
    localparam int BIT_W    = $clog2(MAX_BITS + 1);
    localparam logic [BIT_W-1:0]  NORMAL_LAST = BIT_W'(NORMAL_BURST_BITS - 1);
    localparam logic [BIT_W-1:0]  EDGE_LAST   = BIT_W'(EDGE_BURST_BITS - 1);
    localparam logic [ADDR_W-1:0] STRIDE      = ADDR_W'(BURST_STRIDE);

    frame_req_t frame_req;
    cfg_req_t   cfg_req;

    logic [KEY_BITS-1:0]   key_reg;
    logic                  alg_reg;
    logic                  edge_reg;
    logic [ADDR_W-1:0]     base_reg;

    seq_state_t            state_reg, state_next;
    logic [STEP_W-1:0]     step_cnt_reg;
    logic [BIT_W-1:0]      bit_cnt_reg;
    logic                  burst_reg;
    logic [LOAD_BITS-1:0]  load_sr_reg;
    logic [WORD_W-1:0]     gather_reg;
    logic                  out_valid_reg;
    ks_word_t              out_reg;

    lfsr_ctrl_t            ctrl;
    logic                  ks_bit;
    logic                  frame_acc;
    logic [3:0]            pos;
    logic [BIT_W-1:0]      burst_last;
    logic [STEP_W-1:0]     warm_last;
    logic                  last_bit;
    logic                  word_done;
    logic                  stall;
    logic                  run_step;
    logic [WORD_W-1:0]     word_value;
    logic [ADDR_W-1:0]     word_addr;

    assign frame_req         = frame.payload;
    assign cfg_req           = cfg.payload;
    assign frame.ready       = (state_reg == ST_IDLE);
    assign cfg.ready         = 1'b1;
    assign keystream.valid   = out_valid_reg;
    assign keystream.payload = out_reg;
    assign frame_acc         = frame.valid && frame.ready;

    assign pos        = 4'(bit_cnt_reg);
    assign burst_last = (!alg_reg && edge_reg) ? EDGE_LAST : NORMAL_LAST;
    assign warm_last  = alg_reg ? WARM_LAST_A52 : WARM_LAST_A51;
    assign last_bit   = (bit_cnt_reg == burst_last);
    assign word_done  = (pos == 4'd15) || last_bit;
    assign stall      = word_done && out_valid_reg && !keystream.ready;
    assign word_value = gather_reg | (WORD_W'(ks_bit) << pos);
    assign word_addr  = ADDR_W'(base_reg + (burst_reg ? STRIDE : '0)
                                + ADDR_W'(bit_cnt_reg >> 4));

    gsm_a5_lfsr_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .ks_bit (ks_bit)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_acc)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (step_cnt_reg == LOAD_LAST)
                    state_next = alg_reg ? ST_FIX : ST_WARM;
            end
            ST_FIX:
            begin
                state_next = ST_WARM;
            end
            ST_WARM:
            begin
                if (step_cnt_reg == warm_last)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!stall && last_bit && burst_reg)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        ctrl.a52  = alg_reg;
        run_step  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.clear = frame_acc;
            end
            ST_LOAD:
            begin
                ctrl.step      = 1'b1;
                ctrl.force_clk = 1'b1;
                ctrl.load_en   = 1'b1;
                ctrl.load_bit  = load_sr_reg[0];
            end
            ST_FIX:
            begin
                ctrl.set_fixed = 1'b1;
            end
            ST_WARM:
            begin
                ctrl.step = 1'b1;
            end
            ST_RUN:
            begin
                ctrl.step = !stall;
                run_step  = !stall;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            alg_reg  <= 1'b0;
            edge_reg <= 1'b0;
            base_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_req.cfg_index)
                REG_CIPHER_KEY:       key_reg  <= cfg_req.cfg_data;
                REG_ALGORITHM_SELECT: alg_reg  <= cfg_req.cfg_data[0];
                REG_EDGE_MODE:        edge_reg <= cfg_req.cfg_data[0];
                REG_DESTINATION_BASE: base_reg <= cfg_req.cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            bit_cnt_reg   <= '0;
            burst_reg     <= 1'b0;
            gather_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD || state_reg == ST_WARM)
                step_cnt_reg <= (state_next == state_reg) ? step_cnt_reg + 1'b1 : '0;

            if (run_step && word_done)
                out_valid_reg <= 1'b1;
            else if (keystream.ready)
                out_valid_reg <= 1'b0;

            if (run_step)
            begin
                if (word_done)
                begin
                    gather_reg <= '0;
                end
                else
                begin
                    gather_reg <= word_value;
                end
                if (last_bit)
                begin
                    bit_cnt_reg <= '0;
                    burst_reg   <= !burst_reg;
                end
                else
                begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_acc)
            load_sr_reg <= {frame_req.frame_t1, frame_req.frame_t3, frame_req.frame_t2,
                            key_reg};
        else if (state_reg == ST_LOAD)
            load_sr_reg <= {1'b0, load_sr_reg[LOAD_BITS-1:1]};

        if (run_step && word_done)
        begin
            out_reg.burst_index    <= burst_reg;
            out_reg.word_address   <= word_addr;
            out_reg.keystream_word <= word_value;
            out_reg.valid_bits     <= {WORD_W{1'b1}} >> (4'd15 - pos);
            out_reg.last_word      <= burst_reg && last_bit;
        end
    end

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        frame_acc |=> (state_reg == ST_LOAD && step_cnt_reg == '0))
        else $error("run did not start in load phase");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && stall) |=> ($stable(bit_cnt_reg) && $stable(burst_reg)))
        else $error("bit counter advanced while output word was held");

    a_last_in_second: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last_word) |-> out_reg.burst_index)
        else $error("last word flagged outside second burst");

    a_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WARM || state_reg == ST_IDLE) |-> (bit_cnt_reg == '0 && !burst_reg))
        else $error("burst counters not clear outside output phase");

    a_ready_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !stall && last_bit && burst_reg) |=> frame.ready)
        else $error("not ready after final keystream bit");

endmodule

// ----- rtl/core/gsm_a5_lfsr_core.sv -----
// Four-register LFSR step unit: one forced, majority or R4-clocked step per cycle while ctrl.step is set.
// Depends on gsm_a5_pkg for tap constants and the control struct.

module gsm_a5_lfsr_core
    import gsm_a5_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lfsr_ctrl_t ctrl,
    output logic       ks_bit
);

    logic [18:0] r1_reg, r1_next;
    logic [21:0] r2_reg, r2_next;
    logic [22:0] r3_reg, r3_next;
    logic [16:0] r4_reg, r4_next;
    logic        c1, c2, c3, maj;
    logic        a_maj, b_maj, c_maj, out_a51;

    always_comb
    begin
        if (ctrl.a52)
        begin
            c1 = r4_reg[10];
            c2 = r4_reg[3];
            c3 = r4_reg[7];
        end
        else
        begin
            c1 = r1_reg[8];
            c2 = r2_reg[10];
            c3 = r3_reg[10];
        end
        maj = (c1 & c2) | (c1 & c3) | (c2 & c3);

        r1_next = r1_reg;
        r2_next = r2_reg;
        r3_next = r3_reg;
        r4_next = r4_reg;
        if (ctrl.step)
        begin
            if (ctrl.force_clk || c1 == maj)
                r1_next = {r1_reg[17:0], ^(r1_reg & TAPS_ONE)};
            if (ctrl.force_clk || c2 == maj)
                r2_next = {r2_reg[20:0], ^(r2_reg & TAPS_TWO)};
            if (ctrl.force_clk || c3 == maj)
                r3_next = {r3_reg[21:0], ^(r3_reg & TAPS_THREE)};
            if (ctrl.a52)
                r4_next = {r4_reg[15:0], ^(r4_reg & TAPS_FOUR)};
            if (ctrl.load_en)
            begin
                r1_next[0] = r1_next[0] ^ ctrl.load_bit;
                r2_next[0] = r2_next[0] ^ ctrl.load_bit;
                r3_next[0] = r3_next[0] ^ ctrl.load_bit;
                if (ctrl.a52)
                    r4_next[0] = r4_next[0] ^ ctrl.load_bit;
            end
        end
        if (ctrl.set_fixed)
        begin
            r1_next[15] = 1'b1;
            r2_next[16] = 1'b1;
            r3_next[18] = 1'b1;
            r4_next[10] = 1'b1;
        end
        if (ctrl.clear)
        begin
            r1_next = '0;
            r2_next = '0;
            r3_next = '0;
            r4_next = '0;
        end
    end

    always_comb
    begin
        out_a51 = r1_next[18] ^ r2_next[21] ^ r3_next[22];
        a_maj = (r1_next[15] & ~r1_next[14]) | (r1_next[15] & r1_next[12])
              | (~r1_next[14] & r1_next[12]);
        b_maj = (~r2_next[16] & r2_next[13]) | (~r2_next[16] & r2_next[9])
              | (r2_next[13] & r2_next[9]);
        c_maj = (r3_next[18] & r3_next[16]) | (r3_next[18] & ~r3_next[13])
              | (r3_next[16] & ~r3_next[13]);
        ks_bit = ctrl.a52 ? (out_a51 ^ a_maj ^ b_maj ^ c_maj) : out_a51;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_reg <= '0;
            r2_reg <= '0;
            r3_reg <= '0;
            r4_reg <= '0;
        end
        else
        begin
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            r3_reg <= r3_next;
            r4_reg <= r4_next;
        end
    end

endmodule
